/* rtl/assert_macros.svh */
// Assertion macros shared by the responder RTL.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

/* rtl/sdspi_pkg.sv */
// Shared types and constants for the SD SPI-mode card responder.
// No dependencies; used by the shifter and the top level.
package sdspi_pkg;

    typedef logic [7:0] byte_t;

    // Status of the serial byte shifter
    typedef struct packed {
        logic busy;
        logic last;
    } shift_stat_t;

    // Storage geometry
    localparam int SECTOR_BYTES   = 512;
    localparam int SECTOR_IDX_W   = $clog2(SECTOR_BYTES);
    localparam int STORE_SECTORS  = 64;
    localparam int STORE_SEC_W    = $clog2(STORE_SECTORS);
    localparam int STORE_BYTES    = STORE_SECTORS * SECTOR_BYTES;
    localparam int STORE_ADDR_W   = STORE_SEC_W + SECTOR_IDX_W;
    localparam int SECTOR_COUNT   = 64;
    localparam int IN_STORE_LIMIT =
        (SECTOR_COUNT < STORE_SECTORS) ? SECTOR_COUNT : STORE_SECTORS;

    // Response shift register: up to five bytes
    localparam int RESP_BYTES = 5;
    localparam int RESP_W     = RESP_BYTES * 8;

    // Bytes on the wire
    localparam byte_t FILL_BYTE       = 8'hFF;
    localparam byte_t ZERO_BYTE       = 8'h00;
    localparam byte_t DATA_TOKEN      = 8'hFE;
    localparam byte_t DATA_ACCEPTED   = 8'h05;
    localparam byte_t START_MASK      = 8'hC0;
    localparam byte_t START_BITS      = 8'h40;
    localparam byte_t R1_READY        = 8'h00;
    localparam byte_t R1_IDLE         = 8'h01;
    localparam byte_t R1_ILLEGAL      = 8'h04;
    localparam byte_t IF_COND_VOLTAGE = 8'h01;
    localparam byte_t CHECK_PATTERN   = 8'hAA;
    localparam byte_t OCR_BYTE0       = 8'hC0;
    localparam byte_t OCR_BYTE2       = 8'h80;

    // Command numbers (low six bits of the first command byte)
    localparam logic [5:0] CMD_GO_IDLE       = 6'd0;
    localparam logic [5:0] CMD_SEND_IF_COND  = 6'd8;
    localparam logic [5:0] CMD_READ_SINGLE   = 6'd17;
    localparam logic [5:0] CMD_WRITE_SINGLE  = 6'd24;
    localparam logic [5:0] ACMD_SEND_OP_COND = 6'd41;
    localparam logic [5:0] CMD_APP_CMD       = 6'd55;
    localparam logic [5:0] CMD_READ_OCR      = 6'd58;

    // Sector buffer fill source
    localparam logic [1:0] FILL_IMAGE = 2'd0;
    localparam logic [1:0] FILL_ZERO  = 2'd1;
    localparam logic [1:0] FILL_ONES  = 2'd2;

    // Copy job that follows a word
    localparam logic [1:0] JOB_NONE   = 2'd0;
    localparam logic [1:0] JOB_LOAD   = 2'd1;
    localparam logic [1:0] JOB_COMMIT = 2'd2;

endpackage

/* rtl/sd_card_spi_responder.sv */
// SD card SPI-mode responder, one exchanged byte per word; uses sdspi_pkg, sdspi_shifter, sdspi_ram.
// Exchange: a word taken in C_IDLE is shifted bit-serially in C_SHIFT, handled in C_STEP and loaded
// into the output register in C_PUT, which waits while the output stalls. in_stall holds new words
// until the sequencer is back in C_IDLE. Backdoor writes and deselected words go straight to C_PUT.
// A CMD17 command end, or a CMD24 data end (card present, block in store), adds a RAM sector copy.
// Async reset clears control state; the sector buffer reads as zero until first filled.
`include "assert_macros.svh"

module sd_card_spi_responder (
    input  logic        clk,
    input  logic        rst_n,
    // Input words
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic        chip_select,
    input  logic [7:0]  mosi,
    input  logic [sdspi_pkg::STORE_ADDR_W-1:0] image_address,
    input  logic [7:0]  image_byte,
    // Result words
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  miso,
    // Configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    localparam int IW = sdspi_pkg::SECTOR_IDX_W;
    localparam int SW = sdspi_pkg::STORE_SEC_W;
    localparam int AW = sdspi_pkg::STORE_ADDR_W;
    localparam int RW = sdspi_pkg::RESP_W;

    // Sequencer states
    localparam logic [2:0] C_IDLE   = 3'd0;
    localparam logic [2:0] C_SHIFT  = 3'd1;
    localparam logic [2:0] C_STEP   = 3'd2;
    localparam logic [2:0] C_PUT    = 3'd3;
    localparam logic [2:0] C_LOAD   = 3'd4;
    localparam logic [2:0] C_COMMIT = 3'd5;

    // Card protocol phases
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_CMD        = 4'd1;
    localparam logic [3:0] PH_WAIT_RESP  = 4'd2;
    localparam logic [3:0] PH_SEND_RESP  = 4'd3;
    localparam logic [3:0] PH_READ_WAIT  = 4'd4;
    localparam logic [3:0] PH_READ_DATA  = 4'd5;
    localparam logic [3:0] PH_WRITE_WAIT = 4'd6;
    localparam logic [3:0] PH_WRITE_DATA = 4'd7;
    localparam logic [3:0] PH_WRITE_BUSY = 4'd8;

    logic [2:0]       ctl_reg, ctl_next;
    logic [3:0]       phase_reg, phase_next;
    logic [5:0]       cmd_reg, cmd_next;
    logic [2:0]       cmd_count_reg, cmd_count_next;
    logic             app_pend_reg, app_pend_next;
    logic [RW-1:0]    resp_reg, resp_next;
    logic [2:0]       resp_len_reg, resp_len_next;
    logic [2:0]       resp_idx_reg, resp_idx_next;
    logic [2:0]       wait_reg, wait_next;
    logic [31:0]      blk_reg, blk_next;
    logic [31:0]      arg_reg, arg_next;
    logic [IW-1:0]    data_idx_reg, data_idx_next;
    logic             buf_filled_reg, buf_filled_next;
    logic [1:0]       fill_reg, fill_next;
    logic [1:0]       job_reg, job_next;
    logic [IW:0]      sweep_idx_reg, sweep_idx_next;
    logic             wr_pend_reg, wr_pend_next;
    logic [IW-1:0]    wr_addr_reg, wr_addr_next;
    sdspi_pkg::byte_t res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    sdspi_pkg::byte_t miso_reg, miso_next;
    logic             card_present_reg, card_present_next;

    logic             sh_load;
    sdspi_pkg::shift_stat_t sh_stat;
    logic             sh_rx_bit;
    sdspi_pkg::byte_t sh_rx_byte;
    sdspi_pkg::byte_t sh_tx_byte;
    sdspi_pkg::byte_t miso_now;

    logic             buf_we;
    logic [IW-1:0]    buf_waddr;
    sdspi_pkg::byte_t buf_wdata;
    logic [IW-1:0]    buf_raddr;
    sdspi_pkg::byte_t buf_rdata;

    logic             img_we;
    logic [AW-1:0]    img_waddr;
    sdspi_pkg::byte_t img_wdata;
    logic             img_re;
    logic [AW-1:0]    img_raddr;
    sdspi_pkg::byte_t img_rdata;

    function automatic logic in_store(input logic [31:0] lba);
        in_store = (lba < 32'(sdspi_pkg::IN_STORE_LIMIT));
    endfunction

    // Byte the card returns for the current phase
    always_comb
    begin
        case (phase_reg)
            PH_WAIT_RESP:
                miso_now = (wait_reg != 3'd0) ? sdspi_pkg::FILL_BYTE : resp_reg[RW-1 -: 8];
            PH_SEND_RESP:
                miso_now = resp_reg[RW-1 -: 8];
            PH_READ_WAIT:
                miso_now = (wait_reg != 3'd0) ? sdspi_pkg::FILL_BYTE : sdspi_pkg::DATA_TOKEN;
            PH_READ_DATA:
                miso_now = buf_filled_reg ? buf_rdata : sdspi_pkg::ZERO_BYTE;
            PH_WRITE_BUSY:
                miso_now = (wait_reg != 3'd0) ? sdspi_pkg::FILL_BYTE : sdspi_pkg::DATA_ACCEPTED;
            default:
                miso_now = sdspi_pkg::FILL_BYTE;
        endcase
    end

    // Sequencer and card protocol
    always_comb
    begin
        ctl_next          = ctl_reg;
        phase_next        = phase_reg;
        cmd_next          = cmd_reg;
        cmd_count_next    = cmd_count_reg;
        app_pend_next     = app_pend_reg;
        resp_next         = resp_reg;
        resp_len_next     = resp_len_reg;
        resp_idx_next     = resp_idx_reg;
        wait_next         = wait_reg;
        blk_next          = blk_reg;
        arg_next          = arg_reg;
        data_idx_next     = data_idx_reg;
        buf_filled_next   = buf_filled_reg;
        fill_next         = fill_reg;
        job_next          = job_reg;
        sweep_idx_next    = sweep_idx_reg;
        wr_pend_next      = wr_pend_reg;
        wr_addr_next      = wr_addr_reg;
        res_next          = res_reg;
        miso_next         = miso_reg;
        card_present_next = cfg_valid ? cfg_data : card_present_reg;
        out_valid_next    = out_valid_reg && out_stall;
        sh_load           = 1'b0;
        buf_we            = 1'b0;
        buf_waddr         = data_idx_reg;
        buf_wdata         = sh_rx_byte;
        img_we            = 1'b0;
        img_waddr         = image_address;
        img_wdata         = image_byte;
        img_re            = 1'b0;

        case (ctl_reg)
            C_IDLE:
            begin
                // Take a word: backdoor write, deselected filler, or start an exchange
                if (in_valid)
                begin
                    if (action)
                    begin
                        img_we   = 1'b1;
                        res_next = sdspi_pkg::FILL_BYTE;
                        job_next = sdspi_pkg::JOB_NONE;
                        ctl_next = C_PUT;
                    end
                    else if (chip_select)
                    begin
                        sh_load  = 1'b1;
                        ctl_next = C_SHIFT;
                    end
                    else
                    begin
                        res_next = sdspi_pkg::FILL_BYTE;
                        job_next = sdspi_pkg::JOB_NONE;
                        ctl_next = C_PUT;
                    end
                end
            end

            C_SHIFT:
            begin
                // Gather command argument bytes one bit at a time
                if ((phase_reg == PH_CMD) && (cmd_count_reg <= 3'd4))
                begin
                    arg_next = {arg_reg[30:0], sh_rx_bit};
                end
                if (sh_stat.last)
                begin
                    ctl_next = C_STEP;
                end
            end

            C_STEP:
            begin
                res_next = sh_tx_byte;
                job_next = sdspi_pkg::JOB_NONE;
                ctl_next = C_PUT;
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if ((sh_rx_byte & sdspi_pkg::START_MASK) == sdspi_pkg::START_BITS)
                        begin
                            cmd_next       = sh_rx_byte[5:0];
                            cmd_count_next = 3'd1;
                            phase_next     = PH_CMD;
                        end
                    end
                    PH_CMD:
                    begin
                        cmd_count_next = cmd_count_reg + 3'd1;
                        if (cmd_count_reg == 3'd5)
                        begin
                            // Command complete: pick the response
                            resp_idx_next = 3'd0;
                            wait_next     = 3'd2;
                            phase_next    = PH_WAIT_RESP;
                            resp_len_next = 3'd1;
                            if (app_pend_reg)
                            begin
                                app_pend_next = 1'b0;
                                resp_next = {(cmd_reg == sdspi_pkg::ACMD_SEND_OP_COND) ?
                                             sdspi_pkg::R1_READY : sdspi_pkg::R1_ILLEGAL, 32'h0};
                            end
                            else
                            begin
                                case (cmd_reg)
                                    sdspi_pkg::CMD_GO_IDLE:
                                        resp_next = {sdspi_pkg::R1_IDLE, 32'h0};
                                    sdspi_pkg::CMD_SEND_IF_COND:
                                    begin
                                        resp_next = {sdspi_pkg::R1_IDLE, sdspi_pkg::ZERO_BYTE,
                                                     sdspi_pkg::ZERO_BYTE,
                                                     sdspi_pkg::IF_COND_VOLTAGE,
                                                     sdspi_pkg::CHECK_PATTERN};
                                        resp_len_next = 3'd5;
                                    end
                                    sdspi_pkg::CMD_APP_CMD:
                                    begin
                                        app_pend_next = 1'b1;
                                        resp_next     = {sdspi_pkg::R1_IDLE, 32'h0};
                                    end
                                    sdspi_pkg::CMD_READ_OCR:
                                    begin
                                        resp_next = {sdspi_pkg::R1_READY, sdspi_pkg::OCR_BYTE0,
                                                     sdspi_pkg::FILL_BYTE, sdspi_pkg::OCR_BYTE2,
                                                     sdspi_pkg::ZERO_BYTE};
                                        resp_len_next = 3'd5;
                                    end
                                    sdspi_pkg::CMD_READ_SINGLE:
                                    begin
                                        blk_next  = arg_reg;
                                        job_next  = sdspi_pkg::JOB_LOAD;
                                        resp_next = {sdspi_pkg::R1_READY, 32'h0};
                                        if (!card_present_reg)
                                        begin
                                            fill_next = sdspi_pkg::FILL_ONES;
                                        end
                                        else if (in_store(arg_reg))
                                        begin
                                            fill_next = sdspi_pkg::FILL_IMAGE;
                                        end
                                        else
                                        begin
                                            fill_next = sdspi_pkg::FILL_ZERO;
                                        end
                                    end
                                    sdspi_pkg::CMD_WRITE_SINGLE:
                                    begin
                                        blk_next  = arg_reg;
                                        resp_next = {sdspi_pkg::R1_READY, 32'h0};
                                    end
                                    default:
                                        resp_next = {sdspi_pkg::R1_READY, 32'h0};
                                endcase
                            end
                        end
                    end
                    PH_WAIT_RESP, PH_SEND_RESP:
                    begin
                        if ((phase_reg == PH_WAIT_RESP) && (wait_reg != 3'd0))
                        begin
                            wait_next = wait_reg - 3'd1;
                        end
                        else
                        begin
                            // Drop the byte just sent and advance
                            resp_next     = {resp_reg[RW-9:0], sdspi_pkg::ZERO_BYTE};
                            resp_idx_next = resp_idx_reg + 3'd1;
                            if ((resp_idx_reg + 3'd1) >= resp_len_reg)
                            begin
                                if (cmd_reg == sdspi_pkg::CMD_READ_SINGLE)
                                begin
                                    phase_next = PH_READ_WAIT;
                                    wait_next  = 3'd4;
                                end
                                else if (cmd_reg == sdspi_pkg::CMD_WRITE_SINGLE)
                                begin
                                    phase_next = PH_WRITE_WAIT;
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                end
                            end
                            else
                            begin
                                phase_next = PH_SEND_RESP;
                            end
                        end
                    end
                    PH_READ_WAIT:
                    begin
                        if (wait_reg != 3'd0)
                        begin
                            wait_next = wait_reg - 3'd1;
                        end
                        else
                        begin
                            phase_next    = PH_READ_DATA;
                            data_idx_next = '0;
                        end
                    end
                    PH_READ_DATA:
                    begin
                        data_idx_next = data_idx_reg + 1'b1;
                        if (&data_idx_reg)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_WRITE_WAIT:
                    begin
                        if (sh_rx_byte == sdspi_pkg::DATA_TOKEN)
                        begin
                            phase_next    = PH_WRITE_DATA;
                            data_idx_next = '0;
                        end
                    end
                    PH_WRITE_DATA:
                    begin
                        // Store the host byte in the sector buffer
                        buf_we          = 1'b1;
                        buf_filled_next = 1'b1;
                        data_idx_next   = data_idx_reg + 1'b1;
                        if (&data_idx_reg)
                        begin
                            phase_next = PH_WRITE_BUSY;
                            wait_next  = 3'd2;
                            if (card_present_reg && in_store(blk_reg))
                            begin
                                job_next = sdspi_pkg::JOB_COMMIT;
                            end
                        end
                    end
                    PH_WRITE_BUSY:
                    begin
                        if (wait_reg != 3'd0)
                        begin
                            wait_next = wait_reg - 3'd1;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                        phase_next = PH_IDLE;
                endcase
            end

            C_PUT:
            begin
                // Hand the word to the output register, then run any sector copy
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    miso_next      = res_reg;
                    sweep_idx_next = '0;
                    wr_pend_next   = 1'b0;
                    case (job_reg)
                        sdspi_pkg::JOB_LOAD:
                        begin
                            buf_filled_next = 1'b1;
                            ctl_next        = C_LOAD;
                        end
                        sdspi_pkg::JOB_COMMIT:
                            ctl_next = C_COMMIT;
                        default:
                            ctl_next = C_IDLE;
                    endcase
                end
            end

            C_LOAD, C_COMMIT:
            begin
                // Read one byte per cycle and write it in the cycle after
                if (!sweep_idx_reg[IW])
                begin
                    img_re         = (ctl_reg == C_LOAD);
                    sweep_idx_next = sweep_idx_reg + 1'b1;
                    wr_pend_next   = 1'b1;
                    wr_addr_next   = sweep_idx_reg[IW-1:0];
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    ctl_next     = C_IDLE;
                end
                if (wr_pend_reg)
                begin
                    if (ctl_reg == C_LOAD)
                    begin
                        buf_we    = 1'b1;
                        buf_waddr = wr_addr_reg;
                        case (fill_reg)
                            sdspi_pkg::FILL_IMAGE: buf_wdata = img_rdata;
                            sdspi_pkg::FILL_ONES:  buf_wdata = sdspi_pkg::FILL_BYTE;
                            default:               buf_wdata = sdspi_pkg::ZERO_BYTE;
                        endcase
                    end
                    else
                    begin
                        img_we    = 1'b1;
                        img_waddr = {blk_reg[SW-1:0], wr_addr_reg};
                        img_wdata = buf_rdata;
                    end
                end
            end

            default:
                ctl_next = C_IDLE;
        endcase
    end

    // Read ports
    assign buf_raddr = ((ctl_reg == C_COMMIT) && !sweep_idx_reg[IW]) ?
                       sweep_idx_reg[IW-1:0] : data_idx_reg;
    assign img_raddr = {blk_reg[SW-1:0], sweep_idx_reg[IW-1:0]};

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg          <= C_IDLE;
            phase_reg        <= PH_IDLE;
            cmd_reg          <= 6'd0;
            cmd_count_reg    <= 3'd0;
            app_pend_reg     <= 1'b0;
            resp_len_reg     <= 3'd0;
            resp_idx_reg     <= 3'd0;
            wait_reg         <= 3'd0;
            blk_reg          <= 32'd0;
            data_idx_reg     <= '0;
            buf_filled_reg   <= 1'b0;
            job_reg          <= sdspi_pkg::JOB_NONE;
            sweep_idx_reg    <= '0;
            wr_pend_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            card_present_reg <= 1'b1;
        end
        else
        begin
            ctl_reg          <= ctl_next;
            phase_reg        <= phase_next;
            cmd_reg          <= cmd_next;
            cmd_count_reg    <= cmd_count_next;
            app_pend_reg     <= app_pend_next;
            resp_len_reg     <= resp_len_next;
            resp_idx_reg     <= resp_idx_next;
            wait_reg         <= wait_next;
            blk_reg          <= blk_next;
            data_idx_reg     <= data_idx_next;
            buf_filled_reg   <= buf_filled_next;
            job_reg          <= job_next;
            sweep_idx_reg    <= sweep_idx_next;
            wr_pend_reg      <= wr_pend_next;
            out_valid_reg    <= out_valid_next;
            card_present_reg <= card_present_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        resp_reg    <= resp_next;
        arg_reg     <= arg_next;
        fill_reg    <= fill_next;
        wr_addr_reg <= wr_addr_next;
        res_reg     <= res_next;
        miso_reg    <= miso_next;
    end

    sdspi_shifter u_shifter (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (sh_load),
        .mosi_byte (mosi),
        .miso_byte (miso_now),
        .stat      (sh_stat),
        .rx_bit    (sh_rx_bit),
        .rx_byte   (sh_rx_byte),
        .tx_byte   (sh_tx_byte)
    );

    sdspi_ram #(
        .WIDTH (8),
        .DEPTH (sdspi_pkg::SECTOR_BYTES)
    ) u_sector_buf (
        .clk     (clk),
        .wr_en   (buf_we),
        .wr_addr (buf_waddr),
        .wr_data (buf_wdata),
        .rd_en   (1'b1),
        .rd_addr (buf_raddr),
        .rd_data (buf_rdata)
    );

    sdspi_ram #(
        .WIDTH (8),
        .DEPTH (sdspi_pkg::STORE_BYTES)
    ) u_image_store (
        .clk     (clk),
        .wr_en   (img_we),
        .wr_addr (img_waddr),
        .wr_data (img_wdata),
        .rd_en   (img_re),
        .rd_addr (img_raddr),
        .rd_data (img_rdata)
    );

    assign in_stall  = (ctl_reg != C_IDLE);
    assign out_valid = out_valid_reg;
    assign miso      = miso_reg;
    assign cfg_ready = 1'b1;

    `ASSERT_HOLDS(a_shift_busy, clk, rst_n, ctl_reg == C_SHIFT, sh_stat.busy)
    `ASSERT_HOLDS(a_resp_in_range, clk, rst_n, phase_reg == PH_SEND_RESP, resp_idx_reg < resp_len_reg)
    `ASSERT_HOLDS(a_sweep_bound, clk, rst_n, (ctl_reg == C_LOAD) || (ctl_reg == C_COMMIT), sweep_idx_reg <= (IW+1)'(sdspi_pkg::SECTOR_BYTES))

endmodule

/* rtl/sdspi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdspi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/sdspi_shifter.sv */
// Bit-serial byte exchanger: shifts the host byte in and the card byte out, one bit a cycle.
// Depends on sdspi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sdspi_shifter (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  sdspi_pkg::byte_t         mosi_byte,
    input  sdspi_pkg::byte_t         miso_byte,
    output sdspi_pkg::shift_stat_t   stat,
    output logic                     rx_bit,
    output sdspi_pkg::byte_t         rx_byte,
    output sdspi_pkg::byte_t         tx_byte
);

    logic             busy_reg, busy_next;
    logic [2:0]       cnt_reg, cnt_next;
    sdspi_pkg::byte_t rx_src_reg, rx_src_next;
    sdspi_pkg::byte_t rx_reg, rx_next;
    sdspi_pkg::byte_t tx_src_reg, tx_src_next;
    sdspi_pkg::byte_t tx_reg, tx_next;

    // Load both bytes, then move one bit per cycle until all eight bits are through
    always_comb
    begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        rx_src_next = rx_src_reg;
        rx_next     = rx_reg;
        tx_src_next = tx_src_reg;
        tx_next     = tx_reg;
        if (load)
        begin
            busy_next   = 1'b1;
            cnt_next    = 3'd0;
            rx_src_next = mosi_byte;
            tx_src_next = miso_byte;
        end
        else if (busy_reg)
        begin
            rx_next     = {rx_reg[6:0], rx_src_reg[7]};
            rx_src_next = {rx_src_reg[6:0], 1'b0};
            tx_next     = {tx_reg[6:0], tx_src_reg[7]};
            tx_src_next = {tx_src_reg[6:0], 1'b0};
            cnt_next    = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Shift data
    always_ff @(posedge clk)
    begin
        rx_src_reg <= rx_src_next;
        rx_reg     <= rx_next;
        tx_src_reg <= tx_src_next;
        tx_reg     <= tx_next;
    end

    assign stat.busy = busy_reg;
    assign stat.last = busy_reg && (cnt_reg == 3'd7);
    assign rx_bit    = rx_src_reg[7];
    assign rx_byte   = rx_reg;
    assign tx_byte   = tx_reg;

    `ASSERT_NEXT(a_load_starts, clk, rst_n, load, busy_reg && (cnt_reg == 3'd0))
    `ASSERT_HOLDS(a_no_reload, clk, rst_n, load, !busy_reg)

endmodule
